/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that stays quiet while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/tvg_pkg.sv */
`default_nettype none

package tvg_pkg;

  // Defaults for the top level parameters
  localparam int DEF_ANGLE_BITS = 10;
  localparam int DEF_TRIG_BITS  = 15;
  localparam int DEF_MIN_PARTS  = 3;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAJOR_RADIUS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MINOR_RADIUS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MINOR_PARTS  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAJOR_PARTS  = 2'd3;

  // Register values after reset
  localparam logic [15:0] RST_MAJOR_RADIUS = 16'd512;
  localparam logic [15:0] RST_MINOR_RADIUS = 16'd128;
  localparam logic [7:0]  RST_MINOR_PARTS  = 8'd16;
  localparam logic [7:0]  RST_MAJOR_PARTS  = 8'd16;

  // pi/2 in Q30 and the Taylor divisors (2k)(2k+1)
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // Quarter-wave sine magnitude for table entry q, scaled by 2^trig_bits.
  // Only evaluated at elaboration to fill the sine table.
  function automatic logic [16:0] quarter_sine(input int q, input int angle_bits,
                                               input int trig_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          rnd;
    x    = (longint'(q) * Q30_HALF_PI) >> (angle_bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    rnd = (sum + (longint'(1) << (29 - trig_bits))) >>> (30 - trig_bits);
    return 17'(rnd);
  endfunction

endpackage

`default_nettype wire

/* design/tvg_angle_unit.sv */
`default_nettype none

// Grid index to angle, then sine and cosine of that angle.
// Stage 0 builds the rounded numerator, stages 1..ANGLE_BITS each resolve one
// quotient bit of (k * 2^ANGLE_BITS + parts/2) / parts, stage ANGLE_BITS+1
// reads the quarter-wave table, stage ANGLE_BITS+2 applies the sign.
module tvg_angle_unit import tvg_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS,
  parameter int TRIG_BITS  = DEF_TRIG_BITS
) (
  input  logic                        clk,
  input  logic [ANGLE_BITS+2:0]       en,
  input  logic [7:0]                  k,
  input  logic [7:0]                  parts,
  output logic signed [TRIG_BITS+1:0] sin_val,
  output logic signed [TRIG_BITS+1:0] cos_val
);

  localparam int NUMW    = ANGLE_BITS + 9;
  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int QW      = ANGLE_BITS - 1;
  localparam int MW      = TRIG_BITS + 1;
  localparam int ST_ROM  = ANGLE_BITS + 1;
  localparam int ST_SIGN = ANGLE_BITS + 2;

  typedef logic [MW-1:0] rom_t [QUARTER+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int q = 0; q <= QUARTER; q++) begin
      r[q] = MW'(quarter_sine(q, ANGLE_BITS, TRIG_BITS));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [NUMW-1:0]       num;
  logic [8:0]            rem  [ANGLE_BITS+1];
  logic [ANGLE_BITS-1:0] word [ANGLE_BITS+1];
  logic [9:0]            trial [1:ANGLE_BITS];
  logic [ANGLE_BITS:1]   ge;

  logic [ANGLE_BITS-1:0] phase;
  logic [1:0]            quad;
  logic [QW-1:0]         fwd;
  logic [QW-1:0]         mirror;
  logic [QW-1:0]         addr_s;
  logic [QW-1:0]         addr_c;
  logic [MW-1:0]         mag_s;
  logic [MW-1:0]         mag_c;
  logic                  neg_s;
  logic                  neg_c;

  // Numerator with the half-divisor rounding term
  assign num = NUMW'({k, {ANGLE_BITS{1'b0}}}) + NUMW'(parts >> 1);

  // Restoring divide, one quotient bit per stage
  always_comb begin
    for (int s = 1; s <= ANGLE_BITS; s++) begin
      trial[s] = {rem[s-1], word[s-1][ANGLE_BITS-1]};
      ge[s]    = trial[s] >= {2'b00, parts};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]  <= num[NUMW-1:ANGLE_BITS];
      word[0] <= num[ANGLE_BITS-1:0];
    end
    for (int s = 1; s <= ANGLE_BITS; s++) begin
      if (en[s]) begin
        rem[s]  <= ge[s] ? 9'(trial[s] - {2'b00, parts}) : trial[s][8:0];
        word[s] <= {word[s-1][ANGLE_BITS-2:0], ge[s]};
      end
    end
  end

  // Quadrant fold; cosine is the sine a quarter turn on
  assign phase  = word[ANGLE_BITS];
  assign quad   = phase[ANGLE_BITS-1:ANGLE_BITS-2];
  assign fwd    = {1'b0, phase[ANGLE_BITS-3:0]};
  assign mirror = QW'(QUARTER) - fwd;
  assign addr_s = quad[0] ? mirror : fwd;
  assign addr_c = quad[0] ? fwd : mirror;

  // Table read, registered
  always_ff @(posedge clk) begin
    if (en[ST_ROM]) begin
      mag_s <= SINE_ROM[addr_s];
      mag_c <= SINE_ROM[addr_c];
      neg_s <= quad[1];
      neg_c <= quad[1] ^ quad[0];
    end
  end

  // Sign applied
  always_ff @(posedge clk) begin
    if (en[ST_SIGN]) begin
      sin_val <= neg_s ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
      cos_val <= neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end
  end

endmodule

`default_nettype wire

/* design/torus_wireframe_vertex_generator.sv */
`default_nettype none

// Torus wireframe vertex generator. Each input beat carries a grid position
// (minor_index in s_axis_tdata[7:0], major_index in [15:8]); each output beat
// carries one vertex: x and z in signed Q10.8, y in signed Q8.8, and the
// vertex number and the numbers of its two wrapped edge partners.
// index_error travels in m_axis_tuser and, when set, every tdata field is
// zero. The pipeline takes one beat per clock unless it is full and stalled,
// and returns results in order; its depth is set by the angle divider, which
// resolves one quotient bit per stage, followed by the table read, the sign
// stage and four multiply/round stages. Stalls collapse bubbles, so a result
// waiting on m_axis_tready does not stop input beats until the pipe is full.
// Registers (cfg_addr): 0 major radius R, 1 minor radius r (both Q8.8),
// 2 minor parts, 3 major parts (low 8 bits, raised to MIN_PARTS). Write them
// only while no beat is in flight.
module torus_wireframe_vertex_generator import tvg_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS,
  parameter int TRIG_BITS  = DEF_TRIG_BITS,
  parameter int MIN_PARTS  = DEF_MIN_PARTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // minor_index, major_index
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pos_x, pos_y, pos_z, vertex_number, along_minor_partner,
  // along_major_partner, 4 zero bits
  output logic [103:0]          m_axis_tdata,
  output logic [0:0]            m_axis_tuser,  // index_error
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]           cfg_wdata
);

  localparam int SA     = ANGLE_BITS + 2;   // trig values ready
  localparam int ST_M1  = SA + 1;
  localparam int ST_M2  = SA + 2;
  localparam int ST_M3  = SA + 3;
  localparam int ST_OUT = SA + 4;
  localparam int NS     = SA + 5;
  localparam int TW     = TRIG_BITS + 2;
  localparam int PRW    = 16 + TW;
  localparam int RW     = 18;
  localparam int PXW    = TW + RW;

  localparam logic signed [PRW:0] HALF_PR = (PRW+1)'(64'sd1 <<< (TRIG_BITS - 1));
  localparam logic signed [PXW:0] HALF_PX = (PXW+1)'(64'sd1 <<< (TRIG_BITS - 1));
  localparam logic signed [PRW:0] Y_MAX   = (PRW+1)'(32767);
  localparam logic signed [PRW:0] Y_MIN   = (PRW+1)'(-32768);
  localparam logic signed [PXW:0] X_MAX   = (PXW+1)'(131071);
  localparam logic signed [PXW:0] X_MIN   = (PXW+1)'(-131072);
  localparam logic [7:0]          PARTS_MIN = 8'(MIN_PARTS);

  // Configuration
  logic [15:0] major_radius;
  logic [15:0] minor_radius;
  logic [7:0]  minor_parts;
  logic [7:0]  major_parts;
  logic [7:0]  wr_parts;

  assign wr_parts = (cfg_wdata[7:0] < PARTS_MIN) ? PARTS_MIN : cfg_wdata[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      major_radius <= RST_MAJOR_RADIUS;
      minor_radius <= RST_MINOR_RADIUS;
      minor_parts  <= RST_MINOR_PARTS;
      major_parts  <= RST_MAJOR_PARTS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAJOR_RADIUS: major_radius <= cfg_wdata;
        REG_MINOR_RADIUS: minor_radius <= cfg_wdata;
        REG_MINOR_PARTS:  minor_parts  <= wr_parts;
        REG_MAJOR_PARTS:  major_parts  <= wr_parts;
        default: ;
      endcase
    end
  end

  // Stage valids and bubble-collapsing enables
  logic [NS-1:0] vld;
  logic [NS:0]   en;

  assign en[NS] = m_axis_tready;
  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = ~vld[s] | en[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NS-1];

  // Angles and trig
  logic signed [TW-1:0] sin_u, cos_u, sin_v, cos_v;

  tvg_angle_unit #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_minor_angle (
    .clk    (clk),
    .en     (en[SA:0]),
    .k      (s_axis_tdata[7:0]),
    .parts  (minor_parts),
    .sin_val(sin_u),
    .cos_val(cos_u)
  );

  tvg_angle_unit #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_major_angle (
    .clk    (clk),
    .en     (en[SA:0]),
    .k      (s_axis_tdata[15:8]),
    .parts  (major_parts),
    .sin_val(sin_v),
    .cos_val(cos_v)
  );

  // Index path: capture, products, sums
  logic        err_in;
  logic        err_q [NS];
  logic [7:0]  i0, j0, i1, inext1, jnext0;
  logic [15:0] base1, jbase1;
  logic [15:0] vn_q   [2:NS-1];
  logic [15:0] amin_q [2:NS-1];
  logic [15:0] amaj_q [2:NS-1];

  assign err_in = (s_axis_tdata[7:0] >= minor_parts) || (s_axis_tdata[15:8] >= major_parts);
  assign jnext0 = ({1'b0, j0} + 9'd1 == {1'b0, major_parts}) ? 8'd0 : j0 + 8'd1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      i0       <= s_axis_tdata[7:0];
      j0       <= s_axis_tdata[15:8];
      err_q[0] <= err_in;
    end
    if (en[1]) begin
      i1     <= i0;
      inext1 <= ({1'b0, i0} + 9'd1 == {1'b0, minor_parts}) ? 8'd0 : i0 + 8'd1;
      base1  <= 16'(j0) * 16'(minor_parts);
      jbase1 <= 16'(jnext0) * 16'(minor_parts);
    end
    if (en[2]) begin
      vn_q[2]   <= err_q[1] ? 16'd0 : base1 + 16'(i1);
      amin_q[2] <= err_q[1] ? 16'd0 : base1 + 16'(inext1);
      amaj_q[2] <= err_q[1] ? 16'd0 : jbase1 + 16'(i1);
    end
    for (int s = 1; s < NS; s++) begin
      if (en[s]) begin
        err_q[s] <= err_q[s-1];
      end
    end
    for (int s = 3; s < NS; s++) begin
      if (en[s]) begin
        vn_q[s]   <= vn_q[s-1];
        amin_q[s] <= amin_q[s-1];
        amaj_q[s] <= amaj_q[s-1];
      end
    end
  end

  // Position path
  logic signed [PRW-1:0] prod_rc, prod_rs;
  logic signed [TW-1:0]  cv1, sv1, cv2, sv2;
  logic signed [PRW:0]   rc_sh, ys_sh;
  logic signed [RW-1:0]  ring_next, ring2;
  logic signed [15:0]    y_next, y2, y3, y4;
  logic signed [PXW-1:0] px3, pz3;
  logic signed [PXW:0]   xs_sh, zs_sh;
  logic signed [17:0]    x_next, z_next, x4, z4;

  // r * cos u and r * sin u
  always_ff @(posedge clk) begin
    if (en[ST_M1]) begin
      prod_rc <= $signed(minor_radius) * cos_u;
      prod_rs <= $signed(minor_radius) * sin_u;
      cv1     <= cos_v;
      sv1     <= sin_v;
    end
  end

  // Round, ring radius, saturate y
  always_comb begin
    rc_sh     = ((PRW+1)'(prod_rc) + HALF_PR) >>> TRIG_BITS;
    ys_sh     = ((PRW+1)'(prod_rs) + HALF_PR) >>> TRIG_BITS;
    ring_next = RW'($signed(major_radius)) + RW'($signed(rc_sh[16:0]));
    if (ys_sh > Y_MAX) begin
      y_next = 16'sh7fff;
    end else if (ys_sh < Y_MIN) begin
      y_next = -16'sh8000;
    end else begin
      y_next = ys_sh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_M2]) begin
      ring2 <= ring_next;
      y2    <= y_next;
      cv2   <= cv1;
      sv2   <= sv1;
    end
  end

  // cos v * ring and sin v * ring
  always_ff @(posedge clk) begin
    if (en[ST_M3]) begin
      px3 <= cv2 * ring2;
      pz3 <= sv2 * ring2;
      y3  <= y2;
    end
  end

  // Round, saturate, clear on index error
  always_comb begin
    xs_sh = ((PXW+1)'(px3) + HALF_PX) >>> TRIG_BITS;
    zs_sh = ((PXW+1)'(pz3) + HALF_PX) >>> TRIG_BITS;
    if (xs_sh > X_MAX) begin
      x_next = 18'sh1ffff;
    end else if (xs_sh < X_MIN) begin
      x_next = -18'sh20000;
    end else begin
      x_next = xs_sh[17:0];
    end
    if (zs_sh > X_MAX) begin
      z_next = 18'sh1ffff;
    end else if (zs_sh < X_MIN) begin
      z_next = -18'sh20000;
    end else begin
      z_next = zs_sh[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      x4 <= err_q[ST_M3] ? 18'sd0 : x_next;
      z4 <= err_q[ST_M3] ? 18'sd0 : z_next;
      y4 <= err_q[ST_M3] ? 16'sd0 : y3;
    end
  end

  assign m_axis_tdata = {4'b0000, amaj_q[NS-1], amin_q[NS-1], vn_q[NS-1], z4, y4, x4};
  assign m_axis_tuser = err_q[NS-1];

endmodule

`default_nettype wire

/* design/tvg_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module tvg_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [103:0]          m_axis_tdata,
  input wire logic [0:0]            m_axis_tuser
);

  // Reset empties the pipe
  `ASSERT_CLK(a_rst_empties, clk, (rst |=> !m_axis_tvalid), "output beat valid after reset")

  // A beat flagged as index error carries an all-zero payload
  `ASSERT_CLK_RST(a_err_zero, clk, rst, (m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0), "error beat with non-zero payload")

  // With the output side free the pipe always takes input
  `ASSERT_CLK_RST(a_free_takes, clk, rst, (!m_axis_tvalid || m_axis_tready |-> s_axis_tready), "input held off with output free")

  // A stalled output beat holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled output beat changed")

endmodule

bind torus_wireframe_vertex_generator tvg_checker u_tvg_checker (.*);

`default_nettype wire
